/* rtl/ibst_pkg.sv */
// ibst_pkg: shared types and constants for the implicit-layout search tree
// used by ibst_cmp, ibst_ctrl and implicit_array_bst_insert_find
package ibst_pkg;

  localparam int NODE_SLOTS  = 127;
  localparam int KEY_BITS    = 32;
  localparam int DEPTH       = NODE_SLOTS + 1;
  localparam int SLOT_BITS   = $clog2(DEPTH);
  localparam int POS_BITS    = SLOT_BITS + 1;
  localparam int STATUS_BITS = 3;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FOUND     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_DUPLICATE = 3'd3,
    STAT_NO_ROOM   = 3'd4,
    STAT_ZERO_KEY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_t;

  // comparator result for one tree level
  typedef struct packed {
    logic                eq;
    logic                lt;
    logic [POS_BITS-1:0] child;
    logic                child_out;
  } cmp_t;

  // finished answer handed to the output register
  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [SLOT_BITS-1:0] slot;
  } done_t;

endpackage

/* rtl/ibst_ram.sv */
// ibst_ram: generic single write, single read RAM with registered read data
// no dependencies
module ibst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ibst_cmp.sv */
// ibst_cmp: shared key compare and child index unit, used once per tree level
// depends on ibst_pkg
module ibst_cmp (
  input  logic [ibst_pkg::KEY_BITS-1:0] key,
  input  logic [ibst_pkg::KEY_BITS-1:0] here,
  input  logic [ibst_pkg::POS_BITS-1:0] pos,
  output ibst_pkg::cmp_t                res
);
  import ibst_pkg::*;

  always_comb begin
    res.eq        = (key == here);
    res.lt        = (key < here);
    // left child 2i, right child 2i+1
    res.child     = {pos[POS_BITS-2:0], ~res.lt};
    res.child_out = (res.child > POS_BITS'(NODE_SLOTS));
  end

endmodule

/* rtl/ibst_ctrl.sv */
// ibst_ctrl: walk sequencer, slot valid bits and node store
// depends on ibst_pkg, ibst_ram and ibst_cmp
module ibst_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          action,
  input  logic [31:0]                   key,
  input  logic                          out_free,
  output logic                          busy,
  output ibst_pkg::done_t               done
);
  import ibst_pkg::*;

  state_t               state, state_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic                 is_find;
  logic [KEY_BITS-1:0]  key_q;
  logic [DEPTH-1:0]     valid;
  logic                 vld_q;
  status_t              res_status;
  logic [SLOT_BITS-1:0] res_slot;

  logic [SLOT_BITS-1:0] rd_addr;
  logic [KEY_BITS-1:0]  rd_data;
  logic                 we;
  logic [KEY_BITS-1:0]  key_in;
  cmp_t                 cmp;

  logic                 fin;
  status_t              fin_status;
  logic [SLOT_BITS-1:0] fin_slot;

  assign key_in = key[KEY_BITS-1:0];
  assign busy   = (state != ST_IDLE);

  ibst_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos[SLOT_BITS-1:0]),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ibst_cmp u_cmp (
    .key  (key_q),
    .here (rd_data),
    .pos  (pos),
    .res  (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        valid[pos[SLOT_BITS-1:0]] <= 1'b1;
      end
    end
    vld_q <= valid[rd_addr];
    pos   <= pos_next;
    if (start) begin
      key_q   <= key_in;
      is_find <= action;
    end
    if (fin) begin
      res_status <= fin_status;
      res_slot   <= fin_slot;
    end
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    rd_addr     = pos[SLOT_BITS-1:0];
    we          = 1'b0;
    fin         = 1'b0;
    fin_status  = STAT_NOT_FOUND;
    fin_slot    = '0;
    done.valid  = 1'b0;
    done.status = res_status;
    done.slot   = res_slot;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (key_in == '0) begin
            fin        = 1'b1;
            fin_status = STAT_ZERO_KEY;
          end else begin
            pos_next   = POS_BITS'(1);
            rd_addr    = SLOT_BITS'(1);
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!vld_q) begin
          fin = 1'b1;
          if (is_find) begin
            fin_status = STAT_NOT_FOUND;
          end else begin
            we         = 1'b1;
            fin_status = STAT_INSERTED;
            fin_slot   = pos[SLOT_BITS-1:0];
          end
        end else if (cmp.eq) begin
          fin = 1'b1;
          if (is_find) begin
            fin_status = STAT_FOUND;
            fin_slot   = pos[SLOT_BITS-1:0];
          end else begin
            fin_status = STAT_DUPLICATE;
          end
        end else if (cmp.child_out) begin
          fin        = 1'b1;
          fin_status = is_find ? STAT_NOT_FOUND : STAT_NO_ROOM;
        end else begin
          // read the child during this cycle's compare
          pos_next = cmp.child;
          rd_addr  = cmp.child[SLOT_BITS-1:0];
        end
      end
      ST_RESP: begin
        if (out_free) begin
          done.valid = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        done.valid  = 1'b1;
        done.status = fin_status;
        done.slot   = fin_slot;
        state_next  = ST_IDLE;
      end else begin
        state_next = ST_RESP;
      end
    end
  end

endmodule

/* rtl/implicit_array_bst_insert_find.sv */
// implicit_array_bst_insert_find: top level of the implicit-layout search tree
// depends on ibst_pkg and ibst_ctrl
//
// Binary search tree of nonzero keys kept in a 128-entry node store, root at
// slot 1, children of slot i at 2i (smaller) and 2i+1 (larger). Each request
// is an insert or a find and gives exactly one answer: a status code and a
// slot (0 when there is none). An insert writes the key into the first empty
// slot on its path; a duplicate, a path that runs past slot 127, or a zero
// key is reported and nothing is written. A find stops at the matching slot,
// at an empty slot, or at the end of the store. The store reads as empty
// right after reset (per-slot valid bits, no clearing pass). A request
// takes a transfer step and then a compare at each tree level visited
// (the tree has 7 levels at this size), paced by the one registered read
// of the node store and the shared compare per level; a zero key is
// answered without a walk. The answer sits in an output register, and
// a new request is taken once the previous one has moved its answer there.
module implicit_array_bst_insert_find (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [31:0]                     key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ibst_pkg::STATUS_BITS-1:0] status,
  output logic [ibst_pkg::SLOT_BITS-1:0]   slot
);
  import ibst_pkg::*;

  logic                 busy;
  logic                 start;
  logic                 out_free;
  done_t                done;
  status_t              out_status;
  logic [SLOT_BITS-1:0] out_slot;

  // take a request whenever the walk sequencer is idle
  assign in_stall = busy;
  assign start    = in_valid & ~busy;

  // output register can load when empty or when its transfer completes now
  assign out_free = ~out_valid | ~out_stall;

  ibst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .action   (action),
    .key      (key),
    .out_free (out_free),
    .busy     (busy),
    .done     (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= done.valid;
    end
    if (out_free && done.valid) begin
      out_status <= done.status;
      out_slot   <= done.slot;
    end
  end

  assign status = out_status;
  assign slot   = out_slot;

endmodule
